>>> rtl/mpmg2p_pkg.sv
// Shared types, constants and B-spline helper for the grid-to-particle
// velocity gradient block. No dependencies.
package mpmg2p_pkg;

    // grid size in cells per axis; nodes run from 0 to CELLS_* inclusive
    localparam int CELLS_X = 15;
    localparam int CELLS_Y = 15;
    localparam int CELLS_Z = 15;
    localparam int NODES_X = CELLS_X + 1;
    localparam int NODES_Y = CELLS_Y + 1;
    localparam int NODES_XY = NODES_X * NODES_Y;

    localparam int STORE_AW = 12;
    localparam int STORE_DEPTH = 1 << STORE_AW;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Z = 3'd5;

    localparam logic [30:0] SPACING_RESET = 31'd65536;

    // item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [11:0]        node_index;
        logic signed [31:0] node_vel_x;
        logic signed [31:0] node_vel_y;
        logic signed [31:0] node_vel_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } g2p_in_t;

    typedef struct packed {
        logic signed [31:0] dvx_dx;
        logic signed [31:0] dvy_dx;
        logic signed [31:0] dvz_dx;
        logic signed [31:0] dvx_dy;
        logic signed [31:0] dvy_dy;
        logic signed [31:0] dvz_dy;
        logic signed [31:0] dvx_dz;
        logic signed [31:0] dvy_dz;
        logic signed [31:0] dvz_dz;
    } g2p_out_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vel_t;

    // one node's weight N (Q0.16, unsigned) and slope G (Q1.16, signed)
    typedef struct packed {
        logic [15:0]        n;
        logic signed [17:0] g;
    } bsw_t;

    // quadratic B-spline of a normalized offset d, |d| below 1.5 cells
    function automatic bsw_t bspline(input logic signed [17:0] d);
        logic [16:0] x;
        logic [16:0] r;
        logic [33:0] sq;
        bsw_t        w;
        x = d[17] ? 17'(-d) : d[16:0];
        r = 17'd98304 - x;
        w.n = '0;
        w.g = '0;
        if (x < 17'd32768) begin
            sq  = 34'(x) * 34'(x);
            w.n = 16'd49152 - sq[31:16];
            w.g = -(d <<< 1);
        end else if (x < 17'd98304) begin
            sq  = 34'(r) * 34'(r);
            w.n = sq[32:17];
            w.g = (!d[17] && d != 18'sd0) ? -$signed({1'b0, r}) : $signed({1'b0, r});
        end else begin
            sq = '0;
        end
        return w;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] q);
        logic signed [31:0] r;
        if (q > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (q < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = q[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/mpmg2p_div.sv
// Bit-serial signed floor divider: 64-bit dividend by a positive 39-bit divisor.
// Depends on mpmg2p_pkg.
module mpmg2p_div
    import mpmg2p_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic [38:0]        divisor,
    output logic               done,
    output logic signed [63:0] quotient
);

    logic        busy_reg, busy_next;
    logic        fin_reg, fin_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg;
    logic [38:0] rem_reg;
    logic [63:0] quo_reg;
    logic [38:0] dvs_reg;
    logic        neg_reg;
    logic signed [63:0] q_reg;

    logic [39:0] shl;
    logic [39:0] diff;
    logic        ge;

    assign shl  = {rem_reg, quo_reg[63]};
    assign diff = shl - {1'b0, dvs_reg};
    assign ge   = shl >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg == 6'd0) begin
            busy_next = 1'b0;
            fin_next  = 1'b1;
        end
        if (fin_reg) begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= 6'd63;
            rem_reg <= '0;
            quo_reg <= dividend[63] ? 64'(-dividend) : 64'(dividend);
            neg_reg <= dividend[63];
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 6'd1;
            rem_reg <= ge ? diff[38:0] : shl[38:0];
            quo_reg <= {quo_reg[62:0], ge};
        end
        // floor: a negative quotient with a remainder rounds one further down
        if (fin_reg) begin
            q_reg <= neg_reg ? $signed(~quo_reg + {63'd0, rem_reg == 39'd0})
                             : $signed(quo_reg);
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> rtl/mpmg2p_store.sv
// Grid node velocity store: 4096 x 96 bits, one write and one registered read.
// Depends on mpmg2p_pkg.
module mpmg2p_store
    import mpmg2p_pkg::*;
(
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [STORE_AW-1:0] wr_addr,
    input  vel_t                wr_data,
    input  logic [STORE_AW-1:0] rd_addr,
    output vel_t                rd_data
);

    vel_t store_mem [STORE_DEPTH];
    vel_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/mpm_grid_to_particle_velocity_gradient.sv
// Top level of the grid-to-particle velocity gradient block: control, node
// scan pipeline and result register. Depends on mpmg2p_pkg, mpmg2p_div and
// mpmg2p_store.
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    g2p_in_t  (write node or query)
//   m_        out        m_valid / m_ready    g2p_out_t (nine gradient terms)
//   cfg_      in         cfg_wr_en            cfg_index, cfg_data
//
// A write transaction stores its node and leaves the block idle. A query
// runs the cell coordinate divide, a setup step, 27 node reads and a
// drain, then three rounds of final divides by the spacing. The 64-step
// bit-serial dividers take up most of the time that a query spends.
// One query is in work at a time; s_ready is high only while idle.
// A finished result sits in the output register while the next transaction
// is taken; a query that finishes while m_ stalls holds until it drains.
// Reset is synchronous; the node store has no reset and no clearing pass.
module mpm_grid_to_particle_velocity_gradient
    import mpmg2p_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  g2p_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output g2p_out_t             m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV_T = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DIV_S = 3'd5;
    localparam logic [2:0] ST_DIV_W = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;

    // configuration
    logic signed [31:0] origin_reg [3];
    logic [30:0]        spacing_reg [3];
    logic [30:0]        h_eff [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg[0]  <= '0;
            origin_reg[1]  <= '0;
            origin_reg[2]  <= '0;
            spacing_reg[0] <= SPACING_RESET;
            spacing_reg[1] <= SPACING_RESET;
            spacing_reg[2] <= SPACING_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ORIGIN_X:  origin_reg[0]  <= cfg_data;
                CFG_ORIGIN_Y:  origin_reg[1]  <= cfg_data;
                CFG_ORIGIN_Z:  origin_reg[2]  <= cfg_data;
                CFG_SPACING_X: spacing_reg[0] <= cfg_data[30:0];
                CFG_SPACING_Y: spacing_reg[1] <= cfg_data[30:0];
                CFG_SPACING_Z: spacing_reg[2] <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // a zero spacing acts as the smallest step
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            h_eff[a] = (spacing_reg[a] == 31'd0) ? 31'd1 : spacing_reg[a];
        end
    end

    logic s_accept;
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // scan counters and per-axis setup
    logic [1:0] scan_k_reg, scan_i_reg, scan_j_reg;
    logic       scan_last;
    logic [1:0] comp_reg;
    logic signed [48:0] t_reg [3];
    logic signed [34:0] base_reg [3];
    bsw_t               wt_reg [3][3];

    assign scan_last = (scan_k_reg == 2'd2) && (scan_i_reg == 2'd2) && (scan_j_reg == 2'd2);

    // dividers, one per axis: cell coordinate first, then the final sums
    logic signed [63:0] sum_reg [3][3];
    logic               div_start;
    logic               div_done [3];
    logic signed [63:0] div_q [3];
    logic signed [31:0] pos_sel [3];

    assign pos_sel[0] = s_data.pos_x;
    assign pos_sel[1] = s_data.pos_y;
    assign pos_sel[2] = s_data.pos_z;
    assign div_start  = (s_accept && s_data.mode == MODE_QUERY) || (state_reg == ST_DIV_S);

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [32:0] rel;
        logic signed [63:0] dvd;
        logic [38:0]        dvs;

        assign rel = $signed({pos_sel[a][31], pos_sel[a]})
                   - $signed({origin_reg[a][31], origin_reg[a]});
        assign dvd = (state_reg == ST_IDLE) ? {{15{rel[32]}}, rel, 16'd0}
                                            : sum_reg[a][comp_reg];
        assign dvs = (state_reg == ST_IDLE) ? {8'd0, h_eff[a]} : {h_eff[a], 8'd0};

        mpmg2p_div u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (div_start),
            .dividend (dvd),
            .divisor  (dvs),
            .done     (div_done[a]),
            .quotient (div_q[a])
        );
    end

    // stage A: node address, grid check and first weight products
    logic signed [34:0] node_c [3];
    logic               in_grid;
    logic [23:0]        lin;
    logic [STORE_AW-1:0] rd_addr;
    logic signed [34:0] pa [3];
    vel_t               rd_vel;

    always_comb begin
        node_c[0] = base_reg[0] + $signed({33'd0, scan_i_reg});
        node_c[1] = base_reg[1] + $signed({33'd0, scan_j_reg});
        node_c[2] = base_reg[2] + $signed({33'd0, scan_k_reg});
        in_grid = !node_c[0][34] && node_c[0][33:0] <= 34'(CELLS_X)
               && !node_c[1][34] && node_c[1][33:0] <= 34'(CELLS_Y)
               && !node_c[2][34] && node_c[2][33:0] <= 34'(CELLS_Z);
        lin = 24'(node_c[0][7:0]) * 24'(NODES_Y) + 24'(node_c[1][7:0])
            + 24'(node_c[2][7:0]) * 24'(NODES_XY);
        rd_addr = lin[STORE_AW-1:0];
        pa[0] = wt_reg[0][scan_i_reg].g * $signed({1'b0, wt_reg[1][scan_j_reg].n});
        pa[1] = $signed({1'b0, wt_reg[0][scan_i_reg].n}) * wt_reg[1][scan_j_reg].g;
        pa[2] = $signed({1'b0, wt_reg[0][scan_i_reg].n})
              * $signed({1'b0, wt_reg[1][scan_j_reg].n});
    end

    mpmg2p_store u_store (
        .aclk    (aclk),
        .wr_en   (s_accept && s_data.mode == MODE_WRITE),
        .wr_addr (s_data.node_index),
        .wr_data ({s_data.node_vel_x, s_data.node_vel_y, s_data.node_vel_z}),
        .rd_addr (rd_addr),
        .rd_data (rd_vel)
    );

    // pipeline registers
    logic               vb_reg, vc_reg, vd_reg;
    logic signed [34:0] pb_reg [3];
    logic [15:0]        nz_reg;
    logic signed [17:0] gz_reg;
    logic signed [27:0] w_reg [3];
    logic signed [31:0] v_reg [3];
    logic signed [59:0] prod_reg [3][3];
    logic signed [51:0] mb [3];

    // stage B: finish the weights, product of three factors over 2^24
    assign mb[0] = pb_reg[0] * $signed({1'b0, nz_reg});
    assign mb[1] = pb_reg[1] * $signed({1'b0, nz_reg});
    assign mb[2] = pb_reg[2] * gz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            vb_reg <= (state_reg == ST_SCAN) && in_grid;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < 3; a++) begin
            pb_reg[a] <= pa[a];
            w_reg[a]  <= mb[a][51:24];
        end
        nz_reg   <= wt_reg[2][scan_k_reg].n;
        gz_reg   <= wt_reg[2][scan_k_reg].g;
        v_reg[0] <= rd_vel.x;
        v_reg[1] <= rd_vel.y;
        v_reg[2] <= rd_vel.z;
        // stage C: velocity times weight, nine lanes
        for (int a = 0; a < 3; a++) begin
            for (int c = 0; c < 3; c++) begin
                prod_reg[a][c] <= w_reg[a] * v_reg[c];
            end
        end
    end

    // setup: base node and offsets d = t - node for the three scanned nodes
    logic signed [49:0] tm [3];
    logic signed [17:0] dk [3][3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            tm[a]    = $signed({t_reg[a][48], t_reg[a]}) - 50'sd32768;
            dk[a][0] = $signed({2'b00, tm[a][15:0]}) + 18'sd32768;
            dk[a][1] = dk[a][0] - 18'sd65536;
            dk[a][2] = dk[a][1] - 18'sd65536;
        end
    end

    // result staging
    logic signed [31:0] res_reg [3][3];
    g2p_out_t           m_data_reg;
    logic               m_valid_reg;
    logic               out_load;

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_accept && s_data.mode == MODE_QUERY) state_next = ST_DIV_T;
            ST_DIV_T: if (div_done[0]) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_SCAN;
            ST_SCAN:  if (scan_last) state_next = ST_DRAIN;
            ST_DRAIN: if (!vb_reg && !vc_reg && !vd_reg) state_next = ST_DIV_S;
            ST_DIV_S: state_next = ST_DIV_W;
            ST_DIV_W: begin
                if (div_done[0]) begin
                    state_next = (comp_reg == 2'd2) ? ST_OUT : ST_DIV_S;
                end
            end
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            scan_k_reg  <= '0;
            scan_i_reg  <= '0;
            scan_j_reg  <= '0;
            comp_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // advance the 3x3x3 node scan, j fastest
            if (state_reg == ST_SETUP) begin
                scan_k_reg <= '0;
                scan_i_reg <= '0;
                scan_j_reg <= '0;
                comp_reg   <= '0;
            end else if (state_reg == ST_SCAN) begin
                if (scan_j_reg == 2'd2) begin
                    scan_j_reg <= '0;
                    if (scan_i_reg == 2'd2) begin
                        scan_i_reg <= '0;
                        scan_k_reg <= scan_k_reg + 2'd1;
                    end else begin
                        scan_i_reg <= scan_i_reg + 2'd1;
                    end
                end else begin
                    scan_j_reg <= scan_j_reg + 2'd1;
                end
            end else if (state_reg == ST_DIV_W && div_done[0]) begin
                comp_reg <= comp_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < 3; a++) begin
            if (state_reg == ST_DIV_T && div_done[a]) begin
                t_reg[a] <= div_q[a][48:0];
            end
            if (state_reg == ST_SETUP) begin
                base_reg[a] <= 35'($signed(tm[a][49:16]));
                for (int k = 0; k < 3; k++) begin
                    wt_reg[a][k] <= bspline(dk[a][k]);
                end
            end
            if (state_reg == ST_DIV_W && div_done[a]) begin
                res_reg[a][comp_reg] <= sat32(div_q[a]);
            end
            // stage D: accumulate
            for (int c = 0; c < 3; c++) begin
                if (state_reg == ST_SETUP) begin
                    sum_reg[a][c] <= '0;
                end else if (vd_reg) begin
                    sum_reg[a][c] <= sum_reg[a][c] + prod_reg[a][c];
                end
            end
        end
        if (out_load) begin
            m_data_reg <= {res_reg[0][0], res_reg[0][1], res_reg[0][2],
                           res_reg[1][0], res_reg[1][1], res_reg[1][2],
                           res_reg[2][0], res_reg[2][1], res_reg[2][2]};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done[0] == div_done[1] && div_done[0] == div_done[2])
        else $error("axis dividers out of step");

    a_write_single_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == MODE_WRITE) |=> state_reg == ST_IDLE)
        else $error("node write did not return to idle");

    a_drained_before_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV_S |-> (!vb_reg && !vc_reg && !vd_reg))
        else $error("final divide started with nodes in flight");

    a_pipe_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        vb_reg |-> $past(state_reg) == ST_SCAN)
        else $error("node pipeline loaded outside the scan");
`endif

endmodule

>>> tb/sv/tb_mpm_grid_to_particle_velocity_gradient.sv
`timescale 1ns / 1ps
// Self-checking testbench for mpm_grid_to_particle_velocity_gradient: node writes and
// particle queries with random handshake gaps, checked against a local predictor.
// Depends on mpmg2p_pkg and the block's RTL.
module tb_mpm_grid_to_particle_velocity_gradient;
    import mpmg2p_pkg::*;

    localparam longint Q16_ONE = 65536;
    localparam longint Q16_HALF = 32768;
    localparam longint Q16_3HALF = 98304;
    localparam longint Q16_3QTR = 49152;
    localparam longint RUN_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 400;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    g2p_in_t              s_data;
    logic                 m_valid;
    logic                 m_ready;
    g2p_out_t             m_data;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    mpm_grid_to_particle_velocity_gradient dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Local copy of the block's registers and node store
    longint   grid_org [3];
    longint   grid_pitch [3];
    longint   node_vel [3][STORE_DEPTH];
    bit       node_loaded [STORE_DEPTH];

    g2p_out_t gradient_q[$];
    int       mismatches;
    int       gradients_checked;
    int       nodes_sent;
    int       queries_sent;
    longint   cycle_count;
    bit       calm;     // while set, neither side idles

    // ---------------------------------------------------------------
    // Clock, cycle limit
    // ---------------------------------------------------------------
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d gradients pending", cycle_count,
                     gradient_q.size());
            $display("tb_mpm_grid_to_particle_velocity_gradient: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint sext32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    // Quadratic B-spline weight and slope of a normalized offset
    function automatic void bspline_weight(longint d, output longint n, output longint g);
        longint x;
        longint r;
        x = d < 0 ? -d : d;
        if (x < Q16_HALF) begin
            n = Q16_3QTR - floor_div(x * x, Q16_ONE);
            g = -2 * d;
        end else if (x < Q16_3HALF) begin
            r = Q16_3HALF - x;
            n = floor_div(r * r, 2 * Q16_ONE);
            g = d > 0 ? x - Q16_3HALF : Q16_3HALF - x;
        end else begin
            n = 0;
            g = 0;
        end
    endfunction

    function automatic longint pitch_of(int a);
        return grid_pitch[a] == 0 ? 1 : grid_pitch[a];
    endfunction

    // Returns the first scanned node; fills weights of the three nodes
    function automatic longint cell_scan(int a, logic [31:0] pos,
                                         output longint n [3], output longint g [3]);
        longint t;
        longint base;
        t = floor_div((sext32(pos) - grid_org[a]) * Q16_ONE, pitch_of(a));
        base = floor_div(t - Q16_HALF, Q16_ONE);
        for (int k = 0; k < 3; k++) bspline_weight(t - (base + k) * Q16_ONE, n[k], g[k]);
        return base;
    endfunction

    function automatic int node_addr(longint cx, longint cy, longint cz);
        return int'((cx * NODES_Y + cy + cz * NODES_XY) & (STORE_DEPTH - 1));
    endfunction

    function automatic bit on_grid(longint cx, longint cy, longint cz);
        return cx >= 0 && cx <= CELLS_X && cy >= 0 && cy <= CELLS_Y
            && cz >= 0 && cz <= CELLS_Z;
    endfunction

    function automatic g2p_out_t predict_gradient(g2p_in_t q);
        longint   n [3][3];
        longint   g [3][3];
        longint   base [3];
        longint   acc [3][3];
        longint   w [3];
        longint   r;
        int       adr;
        logic [287:0] flat;
        base[0] = cell_scan(0, q.pos_x, n[0], g[0]);
        base[1] = cell_scan(1, q.pos_y, n[1], g[1]);
        base[2] = cell_scan(2, q.pos_z, n[2], g[2]);
        for (int a = 0; a < 3; a++)
            for (int c = 0; c < 3; c++) acc[a][c] = 0;
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    if (on_grid(base[0] + i, base[1] + j, base[2] + k)) begin
                        adr = node_addr(base[0] + i, base[1] + j, base[2] + k);
                        w[0] = floor_div(g[0][i] * n[1][j] * n[2][k], 64'sd1 <<< 24);
                        w[1] = floor_div(n[0][i] * g[1][j] * n[2][k], 64'sd1 <<< 24);
                        w[2] = floor_div(n[0][i] * n[1][j] * g[2][k], 64'sd1 <<< 24);
                        for (int a = 0; a < 3; a++)
                            for (int c = 0; c < 3; c++)
                                acc[a][c] += node_vel[c][adr] * w[a];
                    end
                end
        for (int a = 0; a < 3; a++)
            for (int c = 0; c < 3; c++) begin
                r = floor_div(acc[a][c], pitch_of(a) * 256);
                if (r > 64'sd2147483647) r = 64'sd2147483647;
                if (r < -64'sd2147483648) r = -64'sd2147483648;
                flat[287 - 32 * (3 * a + c) -: 32] = r[31:0];
            end
        return g2p_out_t'(flat);
    endfunction

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    string term_name [9] = '{"dvx_dx", "dvy_dx", "dvz_dx", "dvx_dy", "dvy_dy",
                             "dvz_dy", "dvx_dz", "dvy_dz", "dvz_dz"};

    always @(posedge aclk) begin
        logic [287:0] got;
        logic [287:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (gradient_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected gradient transaction");
            end else begin
                want = gradient_q.pop_front();
                got = m_data;
                gradients_checked++;
                for (int f = 0; f < 9; f++) begin
                    if (got[287 - 32 * f -: 32] !== want[287 - 32 * f -: 32]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("gradient %0d %s: expected %h, got %h",
                                     gradients_checked, term_name[f],
                                     want[287 - 32 * f -: 32], got[287 - 32 * f -: 32]);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (calm || roll < 55) return 0;
        if (roll < 88) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(20, 4);
        return $urandom_range(150, 30);
    endfunction

    // Random result-side backpressure
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= (calm || $urandom_range(99) < 70) ? 1'b1 : (pick_gap() < 10);
    end

    // Drive one transaction and hold it until taken; update predictor on accept
    task automatic send_item(g2p_in_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        if (item.mode == MODE_WRITE) begin
            node_vel[0][item.node_index] = sext32(item.node_vel_x);
            node_vel[1][item.node_index] = sext32(item.node_vel_y);
            node_vel[2][item.node_index] = sext32(item.node_vel_z);
            node_loaded[item.node_index] = 1'b1;
            nodes_sent++;
        end else begin
            gradient_q.push_back(predict_gradient(item));
            queries_sent++;
        end
    endtask

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2, 3: return $urandom;
            default: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
        endcase
    endfunction

    task automatic write_node(logic [11:0] adr, logic [31:0] vx, logic [31:0] vy,
                              logic [31:0] vz);
        g2p_in_t it;
        it = {1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it.mode = MODE_WRITE;
        it.node_index = adr;
        it.node_vel_x = vx;
        it.node_vel_y = vy;
        it.node_vel_z = vz;
        send_item(it);
    endtask

    // Query a position; first load any scanned on-grid node not yet written
    task automatic query_pos(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        g2p_in_t it;
        longint  n [3];
        longint  g [3];
        longint  bx, by, bz;
        int      adr;
        bx = cell_scan(0, px, n, g);
        by = cell_scan(1, py, n, g);
        bz = cell_scan(2, pz, n, g);
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    if (on_grid(bx + i, by + j, bz + k)) begin
                        adr = node_addr(bx + i, by + j, bz + k);
                        if (!node_loaded[adr])
                            write_node(adr[11:0], rand_vel(), rand_vel(), rand_vel());
                    end
        it = {1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it.mode = MODE_QUERY;
        it.pos_x = px;
        it.pos_y = py;
        it.pos_z = pz;
        send_item(it);
    endtask

    // Position from a cell coordinate (Q16.16 cells); random if it falls off 32 bits
    function automatic logic [31:0] pos_from_cell(int a, longint u);
        longint p;
        p = grid_org[a] + floor_div(u * pitch_of(a), Q16_ONE);
        if (p > 64'sd2147483647 || p < -64'sd2147483648) return $urandom;
        return p[31:0];
    endfunction

    // Cell coordinate in the low or the high corner window; both reach past the grid edge
    function automatic longint rand_cell(bit high);
        longint lo;
        lo = high ? 11 * Q16_ONE : -3 * Q16_ONE;
        case ($urandom_range(9))
            0: return lo + longint'($urandom_range(7)) * Q16_ONE;
            1: return lo + longint'($urandom_range(14)) * Q16_HALF;
            default: return lo + longint'($urandom_range(8 * 65536));
        endcase
    endfunction

    task automatic query_cell(longint ux, longint uy, longint uz);
        query_pos(pos_from_cell(0, ux), pos_from_cell(1, uy), pos_from_cell(2, uz));
    endtask

    // Let outstanding work finish before touching registers
    task automatic settle();
        s_valid <= 1'b0;
        while (gradient_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx <= CFG_ORIGIN_Z) grid_org[idx] = sext32(val);
        else grid_pitch[idx - CFG_SPACING_X] = longint'(val[30:0]);
    endtask

    task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
        settle();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_SPACING_X, hx);
        write_reg(CFG_SPACING_Y, hy);
        write_reg(CFG_SPACING_Z, hz);
    endtask

    // Mix of node refreshes, well-formed queries and stray far-off queries
    task automatic random_traffic(int count);
        bit high;
        for (int t = 0; t < count; t++) begin
            if (t % 64 == 0) calm = ($urandom_range(3) == 0);
            case ($urandom_range(9))
                0, 1: write_node($urandom_range(STORE_DEPTH - 1), rand_vel(), rand_vel(),
                                 rand_vel());
                2: query_pos($urandom, $urandom, $urandom);
                default: begin
                    high = $urandom_range(1);
                    query_cell(rand_cell(high), rand_cell(high), rand_cell(high));
                end
            endcase
        end
        calm = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed_reset_grid();
        write_node(12'd0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000);
        write_node(12'hFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000);
        query_cell(0, 0, 0);                                    // grid corner
        query_cell(15 * Q16_ONE, 15 * Q16_ONE, 15 * Q16_ONE);   // far corner
        query_cell(7 * Q16_ONE + Q16_HALF, 3 * Q16_ONE, 9 * Q16_ONE + 1);
        query_cell(-Q16_ONE - Q16_HALF, 5 * Q16_ONE, 5 * Q16_ONE);  // edge of grid
        query_pos(32'h7FFFFFFF, 32'h80000000, 32'h00000000);    // entirely off grid
        query_pos(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        query_cell(4 * Q16_ONE + Q16_HALF - 1, 4 * Q16_ONE + Q16_HALF,
                   4 * Q16_ONE + Q16_HALF + 1);                 // weight seams
    endtask

    task automatic test_saturation();
        // tiny spacing scales sums far past 32 bits
        set_grid(32'h80000000, 32'h80000000, 32'h80000000, 32'd1, 32'd1, 32'd1);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                write_node(12'(i * NODES_Y + j), 32'h7FFFFFFF, 32'h80000000, $urandom);
        query_pos(32'h80000000, 32'h80000000, 32'h80000000);
        query_pos(32'h80000000 + 1, 32'h80000000 + 1, 32'h80000000 + 3);
        random_traffic(180);
    endtask

    task automatic test_coarse_spacing();
        set_grid(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        query_pos(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        random_traffic(180);
    endtask

    task automatic test_zero_spacing();
        // a spacing of zero acts as one; bit 31 of the data is dropped
        set_grid(32'h0, 32'h0, 32'h0, 32'h80000000, 32'h0, 32'h80000000);
        query_pos(32'd0, 32'd1, 32'd2);
        random_traffic(120);
    endtask

    task automatic test_random_grids();
        for (int p = 0; p < 4; p++) begin
            set_grid($urandom, $urandom, $urandom,
                     $urandom_range(4 * 65536, 8192) | (32'($urandom_range(1)) << 31),
                     $urandom_range(4 * 65536, 8192), $urandom_range(4 * 65536, 8192));
            random_traffic(120);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_ORIGIN_X;
        cfg_data = '0;
        m_ready = 1'b0;
        calm = 1'b0;
        mismatches = 0;
        gradients_checked = 0;
        nodes_sent = 0;
        queries_sent = 0;
        cycle_count = 0;
        for (int a = 0; a < 3; a++) begin
            grid_org[a] = 0;
            grid_pitch[a] = longint'(SPACING_RESET);
        end
        for (int i = 0; i < STORE_DEPTH; i++) begin
            node_loaded[i] = 1'b0;
            for (int c = 0; c < 3; c++) node_vel[c][i] = 0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_reset_grid();
        random_traffic(120);
        test_saturation();
        test_coarse_spacing();
        test_zero_spacing();
        test_random_grids();
        settle();

        $display("covered %0d node writes and %0d particle queries over 8 grid settings",
                 nodes_sent, queries_sent);
        $display("checked %0d gradients, %0d field mismatches", gradients_checked,
                 mismatches);
        if (mismatches == 0 && gradient_q.size() == 0) begin
            $display("tb_mpm_grid_to_particle_velocity_gradient: clean");
        end else begin
            $display("tb_mpm_grid_to_particle_velocity_gradient: errors");
        end
        $finish;
    end

endmodule
